// ===== design/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants for the antialiased circle coverage shader.
// ----------------------------------------------------------------------------
package ccs_pkg;

	// Fixed widths of the register file and derived lengths
	localparam int CEN_W      = 20;  // centre in Q.8
	localparam int LEN_W      = 22;  // radii in Q.8
	localparam int LIM_W      = 13;  // box limits in whole pixels
	localparam int COL_W      = 32;  // RGBA
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int COV_W      = 9;   // coverage 0..256

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STROKE_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STROKE_COLOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

	// Circle set-up as seen by the pipeline
	typedef struct packed {
		logic [CEN_W-1:0] cx;
		logic [CEN_W-1:0] cy;
		logic [LIM_W-1:0] x_lo;
		logic [LIM_W-1:0] x_hi;
		logic [LIM_W-1:0] y_lo;
		logic [LIM_W-1:0] y_hi;
		logic [LEN_W-1:0] inner;
		logic [LEN_W-1:0] inner1;
		logic [LEN_W-1:0] outer;
		logic [LEN_W-1:0] outer1;
		logic [COL_W-1:0] fill;
		logic [COL_W-1:0] stroke;
		logic             stroke_zero;
	} ccs_cfg_t;

endpackage

// ===== design/circle_aa_coverage_shader.sv =====
// ----------------------------------------------------------------------------
// circle_aa_coverage_shader
// Per-pixel antialiased circle fill and stroke draw generator.
// ----------------------------------------------------------------------------
// Use: set the circle with wr_en / wr_index / wr_data (one register a cycle,
// while the block is idle), then feed pixel positions on pixel_x / pixel_y
// with start. A request is taken at a clock edge where start is high and busy
// is low. Each pixel yields zero, one or two draws on draw_x / draw_y /
// draw_color, each shown for one cycle with valid high; last_draw marks the
// final draw of a pixel.
// A request passes through the capture, offset, square and sum registers, the
// square-root pipeline (one root bit per stage) and the shade registers.
// Throughput: one pixel per cycle; a pixel with two draws holds busy high
// for one cycle, during its first draw, so the output register keeps it for the second.
// Reset clears the configuration and valid registers, emptying the pipeline.
// The receiver cannot stall: draws are never held back.
// ----------------------------------------------------------------------------
module circle_aa_coverage_shader #(
	parameter int COORD_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [COORD_BITS-1:0]          pixel_x,
	input  logic [COORD_BITS-1:0]          pixel_y,
	input  logic                           wr_en,
	input  logic [ccs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ccs_pkg::CFG_DATA_W-1:0] wr_data,
	output logic                           valid,
	output logic [COORD_BITS-1:0]          draw_x,
	output logic [COORD_BITS-1:0]          draw_y,
	output logic [ccs_pkg::COL_W-1:0]      draw_color,
	output logic                           last_draw
);
	import ccs_pkg::*;

	localparam int DW  = (COORD_BITS + 8 > CEN_W) ? COORD_BITS + 8 : CEN_W;
	localparam int SW  = 2 * DW + 2;
	localparam int TW  = 2 * COORD_BITS;
	localparam int BXW = LIM_W + 4;

	ccs_cfg_t cfg;
	logic     stall, adv, accept;

	logic                  v_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;

	logic                  inbox;
	logic [BXW-1:0]        bx, by;
	logic signed [DW:0]    ddx, ddy;
	logic                  v_s2;
	logic [COORD_BITS-1:0] x_s2, y_s2;
	logic [DW-1:0]         dx_s2, dy_s2;

	logic                  v_s3;
	logic [COORD_BITS-1:0] x_s3, y_s3;
	logic [2*DW-1:0]       sqx_s3, sqy_s3;

	logic                  v_s4;
	logic [COORD_BITS-1:0] x_s4, y_s4;
	logic [2*DW:0]         sq_s4;

	logic                  sq_valid;
	logic [SW/2-1:0]       sq_root;
	logic [TW-1:0]         sq_tag;

	assign adv    = !stall;
	assign busy   = stall;
	assign accept = start && !busy;

	ccs_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Capture the request and advance the valid flags, culling pixels outside the box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1 && inbox;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Cull to the box and take offsets from the centre
	always_comb begin
		bx    = BXW'(x_s1);
		by    = BXW'(y_s1);
		inbox = (bx >= BXW'(cfg.x_lo)) && (bx <= BXW'(cfg.x_hi)) &&
		        (by >= BXW'(cfg.y_lo)) && (by <= BXW'(cfg.y_hi));
		ddx   = $signed((DW+1)'(cfg.cx)) - $signed((DW+1)'({x_s1, 8'b0}));
		ddy   = $signed((DW+1)'(cfg.cy)) - $signed((DW+1)'({y_s1, 8'b0}));
	end

	// Advance the payload: offsets, squares, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= pixel_x;
			y_s1   <= pixel_y;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			dx_s2  <= ddx[DW] ? DW'(-ddx) : DW'(ddx);
			dy_s2  <= ddy[DW] ? DW'(-ddy) : DW'(ddy);
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			sqx_s3 <= dx_s2 * dx_s2;
			sqy_s3 <= dy_s2 * dy_s2;
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			sq_s4  <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
		end
	end

	ccs_sqrt #(
		.IW (SW),
		.TW (TW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s4),
		.in_val    ({1'b0, sq_s4}),
		.in_tag    ({x_s4, y_s4}),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_tag   (sq_tag)
	);

	ccs_shade #(
		.PW  (COORD_BITS),
		.DIW (SW/2)
	) u_shade (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (sq_valid),
		.in_x       (sq_tag[TW-1:COORD_BITS]),
		.in_y       (sq_tag[COORD_BITS-1:0]),
		.in_dist    (sq_root),
		.stall      (stall),
		.valid      (valid),
		.draw_x     (draw_x),
		.draw_y     (draw_y),
		.draw_color (draw_color),
		.last_draw  (last_draw)
	);

endmodule

// ===== design/ccs_regs.sv =====
// ----------------------------------------------------------------------------
// ccs_regs
// Configuration registers and the circle set-up derived from them.
// ----------------------------------------------------------------------------
module ccs_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ccs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ccs_pkg::CFG_DATA_W-1:0] wr_data,
	output ccs_pkg::ccs_cfg_t              cfg
);
	import ccs_pkg::*;

	logic [15:0]      center_x_q, center_y_q, radius_q, stroke_w_q;
	logic [COL_W-1:0] fill_q, stroke_q;
	logic [12:0]      frame_w_q, frame_h_q;

	logic [19:0]        r_len;
	logic [18:0]        h_len;
	logic [20:0]        rh;
	logic signed [21:0] rmh, rmh1;
	logic [22:0]        lo_x, lo_y;
	logic [21:0]        hi_x, hi_y;
	ccs_cfg_t           cfg_d;

	// Clamp a box edge in Q.8 to whole pixels within 0..limit
	function automatic logic [LIM_W-1:0] box_lim(input logic [22:0] e, input logic [LIM_W-1:0] lim);
		logic [13:0] px;
		begin
			px = e[22] ? 14'd0 : e[21:8];
			box_lim = (px > {1'b0, lim}) ? lim : px[LIM_W-1:0];
		end
	endfunction

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
			stroke_w_q <= '0;
			fill_q     <= '0;
			stroke_q   <= '0;
			frame_w_q  <= '0;
			frame_h_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTER_X:     center_x_q <= wr_data[15:0];
				REG_CENTER_Y:     center_y_q <= wr_data[15:0];
				REG_RADIUS:       radius_q   <= wr_data[15:0];
				REG_STROKE_WIDTH: stroke_w_q <= wr_data[15:0];
				REG_FILL_COLOR:   fill_q     <= wr_data;
				REG_STROKE_COLOR: stroke_q   <= wr_data;
				REG_FRAME_WIDTH:  frame_w_q  <= wr_data[12:0];
				REG_FRAME_HEIGHT: frame_h_q  <= wr_data[12:0];
				default: ;
			endcase
		end
	end

	// Derive radii and the clamped bounding box
	always_comb begin
		r_len = {radius_q, 4'b0};
		h_len = {stroke_w_q, 3'b0};
		rh    = {1'b0, r_len} + {2'b0, h_len};
		rmh   = $signed({2'b0, r_len}) - $signed({3'b0, h_len});
		rmh1  = rmh + 22'sd256;
		lo_x  = {3'b0, center_x_q, 4'b0} - {2'b0, rh};
		lo_y  = {3'b0, center_y_q, 4'b0} - {2'b0, rh};
		hi_x  = {2'b0, center_x_q, 4'b0} + {1'b0, rh};
		hi_y  = {2'b0, center_y_q, 4'b0} + {1'b0, rh};

		cfg_d.cx          = {center_x_q, 4'b0};
		cfg_d.cy          = {center_y_q, 4'b0};
		cfg_d.x_lo        = box_lim(lo_x, frame_w_q);
		cfg_d.y_lo        = box_lim(lo_y, frame_h_q);
		cfg_d.x_hi        = box_lim({1'b0, hi_x}, frame_w_q);
		cfg_d.y_hi        = box_lim({1'b0, hi_y}, frame_h_q);
		cfg_d.inner       = rmh[21] ? 22'(-rmh) : 22'(rmh);
		cfg_d.inner1      = rmh1[21] ? 22'(-rmh1) : 22'(rmh1);
		cfg_d.outer       = {1'b0, rh};
		cfg_d.outer1      = {1'b0, rh} + 22'd256;
		cfg_d.fill        = fill_q;
		cfg_d.stroke      = stroke_q;
		cfg_d.stroke_zero = (stroke_w_q == 16'd0);
	end

	// Hold the set-up in registers to keep it off the pixel path
	always_ff @(posedge clk) begin
		cfg <= cfg_d;
	end

endmodule

// ===== design/ccs_sqrt.sv =====
// ----------------------------------------------------------------------------
// ccs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ccs_sqrt #(
	parameter int IW = 42,
	parameter int TW = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  logic [IW-1:0]   in_val,
	input  logic [TW-1:0]   in_tag,
	output logic            out_valid,
	output logic [IW/2-1:0] out_root,
	output logic [TW-1:0]   out_tag
);
	import ccs_pkg::*;

	localparam int NST = IW / 2;
	localparam int RW  = NST + 3;

	logic            v_s    [1:NST];
	logic [RW-1:0]   rem_s  [1:NST];
	logic [NST-1:0]  root_s [1:NST];
	logic [IW-1:0]   val_s  [1:NST];
	logic [TW-1:0]   tag_s  [1:NST];

	genvar i;
	generate
		for (i = 0; i < NST; i++) begin : g_st
			logic           p_v;
			logic [RW-1:0]  p_rem;
			logic [NST-1:0] p_root;
			logic [IW-1:0]  p_val;
			logic [TW-1:0]  p_tag;
			logic [RW-1:0]  rem_sh, trial;
			logic           ge;

			if (i == 0) begin : g_first
				assign p_v    = in_valid;
				assign p_rem  = '0;
				assign p_root = '0;
				assign p_val  = in_val;
				assign p_tag  = in_tag;
			end else begin : g_next
				assign p_v    = v_s[i];
				assign p_rem  = rem_s[i];
				assign p_root = root_s[i];
				assign p_val  = val_s[i];
				assign p_tag  = tag_s[i];
			end

			// Bring down two bits and try the next root bit
			assign rem_sh = {p_rem[RW-3:0], p_val[IW-1:IW-2]};
			assign trial  = {1'b0, p_root, 2'b01};
			assign ge     = (rem_sh >= trial);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i+1] <= 1'b0;
				end else if (adv) begin
					v_s[i+1] <= p_v;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
					root_s[i+1] <= {p_root[NST-2:0], ge};
					val_s[i+1]  <= {p_val[IW-3:0], 2'b00};
					tag_s[i+1]  <= p_tag;
				end
			end
		end
	endgenerate

	assign out_valid = v_s[NST];
	assign out_root  = root_s[NST];
	assign out_tag   = tag_s[NST];

endmodule

// ===== design/ccs_shade.sv =====
// ----------------------------------------------------------------------------
// ccs_shade
// Classify distance against the radii, fade alpha and issue the draws.
// ----------------------------------------------------------------------------
module ccs_shade #(
	parameter int PW  = 12,
	parameter int DIW = 21
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ccs_pkg::ccs_cfg_t        cfg,
	input  logic                     in_valid,
	input  logic [PW-1:0]            in_x,
	input  logic [PW-1:0]            in_y,
	input  logic [DIW-1:0]           in_dist,
	output logic                     stall,
	output logic                     valid,
	output logic [PW-1:0]            draw_x,
	output logic [PW-1:0]            draw_y,
	output logic [ccs_pkg::COL_W-1:0] draw_color,
	output logic                     last_draw
);
	import ccs_pkg::*;

	localparam int CW = ((DIW > LEN_W) ? DIW : LEN_W) + 2;

	typedef enum logic [2:0] {
		KD_NONE,
		KD_FILL,
		KD_STROKE,
		KD_FILL_FADE,
		KD_STROKE_FADE,
		KD_FILL_EDGE
	} kind_t;

	logic        adv;
	logic [CW-1:0] dist_v, inner, inner1, outer, outer1;
	logic signed [CW-1:0] diff;
	logic        inner_edge;
	kind_t       kind;
	logic [COV_W-1:0] cov;

	logic             v_s1;
	kind_t            kind_s1;
	logic [COV_W-1:0] cov_s1;
	logic [PW-1:0]    x_s1, y_s1;

	logic [COL_W-1:0] c0, c1;
	logic             two;
	logic             v_s2;
	logic [PW-1:0]    x_s2, y_s2;
	logic [COL_W-1:0] c0_s2, c1_s2;
	logic             two_s2;
	logic             phase_q;

	// Scale alpha by coverage, keep RGB
	function automatic logic [COL_W-1:0] fade(input logic [COL_W-1:0] c, input logic [COV_W-1:0] k);
		logic [16:0] p;
		begin
			p    = c[7:0] * k;
			fade = {c[COL_W-1:8], p[15:8]};
		end
	endfunction

	assign adv = !stall;

	// Classify the distance
	always_comb begin
		dist_v = CW'(in_dist);
		inner  = CW'(cfg.inner);
		inner1 = CW'(cfg.inner1);
		outer  = CW'(cfg.outer);
		outer1 = CW'(cfg.outer1);
		inner_edge = 1'b0;
		if (dist_v >= outer1) begin
			kind = KD_NONE;
		end else if (dist_v <= inner) begin
			kind = KD_FILL;
		end else if (cfg.stroke_zero) begin
			kind = KD_FILL_FADE;
		end else if (dist_v <= outer) begin
			if (dist_v >= inner1) begin
				kind = KD_STROKE;
			end else begin
				kind = KD_FILL_EDGE;
				inner_edge = 1'b1;
			end
		end else begin
			kind = KD_STROKE_FADE;
		end
		diff = inner_edge ? $signed(dist_v - inner) : $signed(outer1 - dist_v);
		if (diff < 0) begin
			cov = '0;
		end else if (diff > $signed(CW'(256))) begin
			cov = COV_W'(256);
		end else begin
			cov = diff[COV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && (kind != KD_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			cov_s1  <= cov;
			x_s1    <= in_x;
			y_s1    <= in_y;
		end
	end

	// Pick the draw colours
	always_comb begin
		c1  = fade(cfg.stroke, cov_s1);
		two = 1'b0;
		case (kind_s1)
			KD_FILL:        c0 = cfg.fill;
			KD_STROKE:      c0 = cfg.stroke;
			KD_FILL_FADE:   c0 = fade(cfg.fill, cov_s1);
			KD_STROKE_FADE: c0 = c1;
			KD_FILL_EDGE: begin
				c0  = cfg.fill;
				two = 1'b1;
			end
			default:        c0 = cfg.fill;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s2 <= v_s1;
			end
			phase_q <= stall;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			c0_s2  <= c0;
			c1_s2  <= c1;
			two_s2 <= two;
		end
	end

	// Hold the pipeline for one cycle during the first draw so the second can go out
	assign stall      = v_s2 && two_s2 && !phase_q;
	assign valid      = v_s2;
	assign draw_x     = x_s2;
	assign draw_y     = y_s2;
	assign draw_color = phase_q ? c1_s2 : c0_s2;
	assign last_draw  = !stall;

`ifndef NO_ASSERTIONS
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (phase_q && valid && last_draw))
		else $error("second draw did not follow the first");
	a_phase_cause: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (v_s2 && two_s2 && $past(stall)))
		else $error("second draw without a held two-draw request");
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> ($stable(x_s2) && $stable(y_s2) && $stable(c1_s2)))
		else $error("output stage changed while held");
`endif

endmodule

// ===== tb/circle_aa_coverage_shader_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_aa_coverage_shader_checker
// Watches the register port, the pixel requests and the draw outputs of the
// circle shader, predicts the draws of every accepted pixel and compares
// them in order with what the block puts out.
// ----------------------------------------------------------------------------
module circle_aa_coverage_shader_checker (
	input  logic                           clk,
	input  logic                           start,
	input  logic                           busy,
	input  logic [11:0]                    pixel_x,
	input  logic [11:0]                    pixel_y,
	input  logic                           wr_en,
	input  logic [ccs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ccs_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           valid,
	input  logic [11:0]                    draw_x,
	input  logic [11:0]                    draw_y,
	input  logic [31:0]                    draw_color,
	input  logic                           last_draw,
	output int                             err_count,
	output int                             draws_pending
);
	import ccs_pkg::*;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [31:0] color;
		logic        last;
	} draw_t;

	draw_t draw_queue[$];

	logic [15:0] cen_x, cen_y, radius, stroke_w;
	logic [31:0] fill_col, stroke_col;
	logic [12:0] frame_w, frame_h;

	initial begin
		cen_x = '0; cen_y = '0; radius = '0; stroke_w = '0;
		fill_col = '0; stroke_col = '0; frame_w = '0; frame_h = '0;
		err_count = 0;
	end

	assign draws_pending = draw_queue.size();

	// Integer square root, one result bit per pass
	function automatic longint root_floor(longint unsigned v);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return longint'(res);
	endfunction

	// Scale the alpha byte by coverage clamped to one pixel
	function automatic logic [31:0] faded(logic [31:0] col, longint cov);
		longint a;
		if (cov < 0) cov = 0;
		if (cov > 256) cov = 256;
		a = (longint'(col[7:0]) * cov) >> 8;
		return {col[31:8], a[7:0]};
	endfunction

	function automatic longint box_edge(longint e, longint lim);
		longint v;
		v = (e < 0) ? 0 : e / 256;
		return (v > lim) ? lim : v;
	endfunction

	function automatic void push_draw(logic [11:0] x, logic [11:0] y,
			logic [31:0] col, logic last);
		draw_t d;
		d.x = x; d.y = y; d.color = col; d.last = last;
		draw_queue.push_back(d);
	endfunction

	// Work out the draws caused by one pixel
	function automatic void predict_pixel(logic [11:0] px, logic [11:0] py);
		longint cx, cy, r, h, inner, inner1, outer, outer1, dx, dy, dist_v;
		longint lx, ly;
		cx = longint'(cen_x) << 4;
		cy = longint'(cen_y) << 4;
		r = longint'(radius) << 4;
		h = longint'(stroke_w) << 3;
		inner = (r - h < 0) ? h - r : r - h;
		inner1 = (r - h + 256 < 0) ? -(r - h + 256) : r - h + 256;
		outer = r + h;
		outer1 = r + h + 256;
		lx = longint'(px);
		ly = longint'(py);
		if (lx < box_edge(cx - r - h, frame_w) || lx > box_edge(cx + r + h, frame_w) ||
				ly < box_edge(cy - r - h, frame_h) || ly > box_edge(cy + r + h, frame_h))
			return;
		dx = cx - (lx << 8);
		dy = cy - (ly << 8);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		dist_v = root_floor(dx * dx + dy * dy);
		if (dist_v >= outer1)
			return;
		if (dist_v <= inner)
			push_draw(px, py, fill_col, 1'b1);
		else if (stroke_w == 0)
			push_draw(px, py, faded(fill_col, outer1 - dist_v), 1'b1);
		else if (dist_v <= outer && dist_v >= inner1)
			push_draw(px, py, stroke_col, 1'b1);
		else if (dist_v <= outer) begin
			push_draw(px, py, fill_col, 1'b0);
			push_draw(px, py, faded(stroke_col, dist_v - inner), 1'b1);
		end else
			push_draw(px, py, faded(stroke_col, outer1 - dist_v), 1'b1);
	endfunction

	// Track register writes, predict on each request, check each draw
	always @(posedge clk) begin
		draw_t exp_d;
		if (wr_en) begin
			case (wr_index)
				REG_CENTER_X:     cen_x <= wr_data[15:0];
				REG_CENTER_Y:     cen_y <= wr_data[15:0];
				REG_RADIUS:       radius <= wr_data[15:0];
				REG_STROKE_WIDTH: stroke_w <= wr_data[15:0];
				REG_FILL_COLOR:   fill_col <= wr_data;
				REG_STROKE_COLOR: stroke_col <= wr_data;
				REG_FRAME_WIDTH:  frame_w <= wr_data[12:0];
				REG_FRAME_HEIGHT: frame_h <= wr_data[12:0];
				default: ;
			endcase
		end
		if (start && !busy)
			predict_pixel(pixel_x, pixel_y);
		if (valid) begin
			if (draw_queue.size() == 0) begin
				if (err_count < 10)
					$display("unexpected draw x=%0d y=%0d colour=%h last=%b",
						draw_x, draw_y, draw_color, last_draw);
				err_count <= err_count + 1;
			end else begin
				exp_d = draw_queue.pop_front();
				if (exp_d.x !== draw_x || exp_d.y !== draw_y ||
						exp_d.color !== draw_color || exp_d.last !== last_draw) begin
					if (err_count < 10)
						$display("draw mismatch: expected x=%0d y=%0d colour=%h last=%b, got x=%0d y=%0d colour=%h last=%b",
							exp_d.x, exp_d.y, exp_d.color, exp_d.last,
							draw_x, draw_y, draw_color, last_draw);
					err_count <= err_count + 1;
				end
			end
		end
	end

endmodule

// ===== tb/circle_aa_coverage_shader_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_aa_coverage_shader_test
// Drives register settings and pixel requests into the circle shader; a
// checker beside the block predicts and compares the draws. Directed
// circles cover the special cases, then random circles, sent in bursts with
// random gaps, with pixels mostly near the circle.
// ----------------------------------------------------------------------------
module circle_aa_coverage_shader_test;
	import ccs_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [11:0] pixel_x = '0, pixel_y = '0;
	logic        wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic        valid;
	logic [11:0] draw_x, draw_y;
	logic [31:0] draw_color;
	logic        last_draw;
	int          err_count, draws_pending;

	int burst_left = 0;
	int circ_px, circ_py, circ_span;

	circle_aa_coverage_shader #(.COORD_BITS(12)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.valid(valid), .draw_x(draw_x), .draw_y(draw_y),
		.draw_color(draw_color), .last_draw(last_draw)
	);

	circle_aa_coverage_shader_checker chk (
		.clk(clk), .start(start), .busy(busy),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.valid(valid), .draw_x(draw_x), .draw_y(draw_y),
		.draw_color(draw_color), .last_draw(last_draw),
		.err_count(err_count), .draws_pending(draws_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Give up after a generous time
	initial begin
		#4000000;
		$display("circle_aa_coverage_shader_test: done, errors");
		$finish;
	end

	// Drop the request, hold until every draw has come, then let the pipeline drain
	task automatic drain();
		start <= 1'b0;
		while (draws_pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_circle(logic [15:0] cx, logic [15:0] cy, logic [15:0] r,
			logic [15:0] sw, logic [31:0] fc, logic [31:0] sc,
			logic [12:0] fw, logic [12:0] fh);
		logic [31:0] vals[8];
		vals = '{cx, cy, r, sw, fc, sc, fw, fh};
		drain();
		for (int i = 0; i < 8; i++) begin
			wr_en <= 1'b1;
			wr_index <= CFG_IDX_W'(i);
			wr_data <= vals[i];
			@(posedge clk);
		end
		wr_en <= 1'b0;
		circ_px = cx >> 4;
		circ_py = cy >> 4;
		circ_span = ((r + (sw >> 1)) >> 4) + 3;
	endtask

	// Present one request and hold it until taken
	task automatic send_pixel(int x, int y, bit gaps);
		bit ok;
		int gap;
		if (gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		start <= 1'b1;
		pixel_x <= 12'(x);
		pixel_y <= 12'(y);
		forever begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
			if (ok) break;
		end
	endtask

	function automatic int near_coord(int c);
		int v;
		v = c + $urandom_range(0, 2 * circ_span) - circ_span;
		return (v < 0) ? 0 : (v > 4095 ? 4095 : v);
	endfunction

	initial begin
		int n_items;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Stroked circle: fill, ring, box cull
		set_circle(16'd1608, 16'd1604, 16'd320, 16'd64, 32'h11223380, 32'hAABBCCFF,
			13'd4096, 13'd4096);
		send_pixel(100, 100, 0);
		send_pixel(118, 100, 0);
		send_pixel(120, 100, 0);
		send_pixel(122, 100, 0);
		send_pixel(123, 100, 0);
		send_pixel(100, 79, 0);
		send_pixel(0, 0, 0);
		send_pixel(4095, 4095, 0);
		// Fill only, no stroke, with pixels at and past its box edge
		set_circle(16'd800, 16'd800, 16'd200, 16'd0, 32'hFFFFFFFF, 32'h0, 13'd4096, 13'd4096);
		send_pixel(50, 50, 0);
		send_pixel(62, 50, 0);
		send_pixel(63, 50, 0);
		send_pixel(64, 50, 0);
		// Stroke wider than the diameter, frame clamp at zero
		set_circle(16'd0, 16'd0, 16'd16, 16'd200, 32'h12345678, 32'h9ABCDEF0, 13'd0, 13'd0);
		send_pixel(0, 0, 0);
		send_pixel(1, 0, 0);
		// Extreme registers: huge radius and far centre
		set_circle(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			13'd4096, 13'd4096);
		send_pixel(4095, 4095, 0);
		send_pixel(4095, 0, 0);
		set_circle(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 32'h0, 32'h0, 13'd4096, 13'd4096);
		send_pixel(4095, 4095, 0);
		send_pixel(4095, 4094, 0);
		// Clamp with box beyond a small frame
		set_circle(16'd480, 16'd480, 16'd400, 16'd32, 32'h55AA55AA, 32'hAA55AA55,
			13'd35, 13'd34);
		send_pixel(35, 34, 0);
		send_pixel(36, 30, 0);
		send_pixel(30, 35, 0);

		// Random circles, mostly small, pixels mostly near the circle
		n_items = 0;
		while (n_items < 1450) begin
			set_circle(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
				16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1200)),
				16'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300)),
				$urandom, $urandom,
				13'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4096) : 4096),
				13'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4096) : 4096));
			if (circ_span > 200) circ_span = 200;
			repeat ($urandom_range(60, 180)) begin
				if ($urandom_range(0, 9) < 8)
					send_pixel(near_coord(circ_px), near_coord(circ_py), 1);
				else
					send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), 1);
				n_items++;
			end
			start <= 1'b0;
		end
		start <= 1'b0;

		drain();
		if (err_count == 0 && draws_pending == 0)
			$display("circle_aa_coverage_shader_test: done, clean");
		else
			$display("circle_aa_coverage_shader_test: done, errors");
		$finish;
	end

endmodule

// ===== circle_aa_coverage_shader.f =====
design/ccs_pkg.sv
design/ccs_regs.sv
design/ccs_sqrt.sv
design/ccs_shade.sv
design/circle_aa_coverage_shader.sv
tb/circle_aa_coverage_shader_checker.sv
tb/circle_aa_coverage_shader_test.sv
